/* rtl/sha256sh_pkg.sv */
// ----------------------------------------------------------------------------
// sha256sh_pkg: shared types and constants of the SHA-256 stream hasher
// Round constants, initial hash values, sequencer states and the control
// bundle that the sequencer drives into the datapath.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
  localparam logic [5:0] LEN_FILL      = 6'd56;
  localparam logic [5:0] LAST_SLOT     = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
  localparam logic [1:0] LAST_WORD     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // What follows the compression in flight
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_LAST
  } phase_t;

  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_chain;
    logic       init_chain;
    logic [1:0] word_sel;
  } ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

/* rtl/sha256_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top: byte-stream SHA-256 hasher
// Collects message bytes into 64-byte blocks, compresses each full block,
// pads on end of message and returns the 256-bit digest as four 64-bit words.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | data_byte, byte_present, end_of_message
//  out     | out_valid / out_ready| digest_word, digest_last
//
//  A byte that does not complete a block is just shifted in. A byte that
//  completes a block adds 64 rounds of the shared round unit plus the chaining
//  add. An end transaction adds one padding byte per slot up to offset 56, a
//  step into the length, 8 length bytes, the rounds and chaining add of each
//  final block (one or two), then the four digest words.
//  in_ready is high only while the sequencer is idle; one transaction is in
//  work at a time. The output register holds each word until out_ready, and
//  the sequencer stalls on it. Reset returns the chaining words to the
//  initial hash values and clears all counters; no clearing pass is needed.
//
module sha256_stream_hasher_top
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic        digest_last
);

  ctl_t        ctl;
  logic        out_free;
  logic        out_load;
  logic        out_last;
  logic [63:0] core_word;

  // The output register may take a new word when empty or being drained
  assign out_free = !out_valid || out_ready;

  sha256sh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_free       (out_free),
    .out_load       (out_load),
    .out_last       (out_last),
    .ctl            (ctl)
  );

  sha256sh_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .word_out (core_word)
  );

  // Hold valid until out_ready takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the selected digest word
  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word <= core_word;
      digest_last <= out_last;
    end
  end

endmodule

/* rtl/sha256sh_core.sv */
// ----------------------------------------------------------------------------
// sha256sh_core: SHA-256 datapath
// Holds the 512-bit block window (doubles as the rolling message schedule),
// the working variables a..h and the chaining words; runs one round a cycle.
// ----------------------------------------------------------------------------
module sha256sh_core
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output logic [63:0] word_out
);

  logic [511:0] win;
  logic [31:0]  rv [8];
  logic [31:0]  chain [8];

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, t1, t2, big0, big1, ch, maj;

  assign w0  = win[511:480];
  assign w1  = win[479:448];
  assign w9  = win[223:192];
  assign w14 = win[63:32];

  always_comb begin
    s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = w0 + s0 + w9 + s1;
    big1  = rotr(rv[4], 6) ^ rotr(rv[4], 11) ^ rotr(rv[4], 25);
    ch    = (rv[4] & rv[5]) ^ (~rv[4] & rv[6]);
    big0  = rotr(rv[0], 2) ^ rotr(rv[0], 13) ^ rotr(rv[0], 22);
    maj   = (rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]);
    t1    = rv[7] + big1 + ch + ROUND_K[ctl.round_idx] + w0;
    t2    = big0 + maj;
  end

  // Window: bytes enter at the bottom; rounds consume the top word
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      win <= {win[503:0], ctl.shift_byte};
    end else if (ctl.round_en) begin
      win <= {win[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      rv <= chain;
    end else if (ctl.round_en) begin
      rv[7] <= rv[6];
      rv[6] <= rv[5];
      rv[5] <= rv[4];
      rv[4] <= rv[3] + t1;
      rv[3] <= rv[2];
      rv[2] <= rv[1];
      rv[1] <= rv[0];
      rv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init_chain) begin
      chain <= INIT_H;
    end else if (ctl.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + rv[i];
      end
    end
  end

  assign word_out = {chain[{ctl.word_sel, 1'b0}], chain[{ctl.word_sel, 1'b1}]};

endmodule

/* rtl/sha256sh_ctrl.sv */
// ----------------------------------------------------------------------------
// sha256sh_ctrl: sequencer of the SHA-256 stream hasher
// Tracks fill and message length, drives byte loading, padding, the 64
// rounds, the chaining add and the four digest words.
// ----------------------------------------------------------------------------
module sha256sh_ctrl
  import sha256sh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  logic       out_free,
  output logic       out_load,
  output logic       out_last,
  output ctl_t       ctl
);

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic        pend_end, pend_end_next;
  logic [5:0]  fill, fill_next;
  logic [5:0]  round_idx, round_idx_next;
  logic [2:0]  len_idx, len_idx_next;
  logic [1:0]  word_idx, word_idx_next;
  logic [60:0] msg_bytes, msg_bytes_next;

  logic [63:0] bit_len;
  logic [7:0]  len_bytes [8];

  always_comb begin
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) begin
      len_bytes[i] = bit_len[63 - 8 * i -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_DATA;
      pend_end  <= 1'b0;
      fill      <= '0;
      round_idx <= '0;
      len_idx   <= '0;
      word_idx  <= '0;
      msg_bytes <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      pend_end  <= pend_end_next;
      fill      <= fill_next;
      round_idx <= round_idx_next;
      len_idx   <= len_idx_next;
      word_idx  <= word_idx_next;
      msg_bytes <= msg_bytes_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    pend_end_next  = pend_end;
    fill_next      = fill;
    round_idx_next = round_idx;
    len_idx_next   = len_idx;
    word_idx_next  = word_idx;
    msg_bytes_next = msg_bytes;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    out_last       = 1'b0;
    ctl            = '0;
    ctl.round_idx  = round_idx;
    ctl.word_sel   = word_idx;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (byte_present) begin
            ctl.shift_en   = 1'b1;
            ctl.shift_byte = data_byte;
            fill_next      = fill + 6'd1;
            msg_bytes_next = msg_bytes + 61'd1;
            pend_end_next  = end_of_message;
            if (fill == LAST_SLOT) begin
              ctl.load_vars  = 1'b1;
              phase_next     = PH_DATA;
              round_idx_next = '0;
              state_next     = ST_ROUND;
            end else if (end_of_message) begin
              state_next = ST_PAD_MARK;
            end
          end else if (end_of_message) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        ctl.shift_en   = 1'b1;
        ctl.shift_byte = PAD_MARK_BYTE;
        fill_next      = fill + 6'd1;
        pend_end_next  = 1'b0;
        if (fill == LAST_SLOT) begin
          ctl.load_vars  = 1'b1;
          phase_next     = PH_PAD;
          round_idx_next = '0;
          state_next     = ST_ROUND;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill == LEN_FILL) begin
          len_idx_next = '0;
          state_next   = ST_PAD_LEN;
        end else begin
          ctl.shift_en   = 1'b1;
          ctl.shift_byte = PAD_ZERO_BYTE;
          fill_next      = fill + 6'd1;
          if (fill == LAST_SLOT) begin
            ctl.load_vars  = 1'b1;
            phase_next     = PH_PAD;
            round_idx_next = '0;
            state_next     = ST_ROUND;
          end
        end
      end
      ST_PAD_LEN: begin
        ctl.shift_en   = 1'b1;
        ctl.shift_byte = len_bytes[len_idx];
        fill_next      = fill + 6'd1;
        len_idx_next   = len_idx + 3'd1;
        if (len_idx == LAST_LEN_BYTE) begin
          ctl.load_vars  = 1'b1;
          phase_next     = PH_LAST;
          round_idx_next = '0;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round_en   = 1'b1;
        round_idx_next = round_idx + 6'd1;
        if (round_idx == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl.add_chain = 1'b1;
        unique case (phase)
          PH_DATA: state_next = pend_end ? ST_PAD_MARK : ST_IDLE;
          PH_PAD:  state_next = ST_PAD_ZERO;
          PH_LAST: begin
            word_idx_next = '0;
            state_next    = ST_EMIT;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_last      = (word_idx == LAST_WORD);
          word_idx_next = word_idx + 2'd1;
          if (word_idx == LAST_WORD) begin
            ctl.init_chain = 1'b1;
            msg_bytes_next = '0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
